FILE: rtl/fla_pkg.sv
// ----------------------------------------------------------------------------
// fla_pkg
// Shared types and constants of the free-list allocator: field widths, reset
// values of the configuration registers, action and status codes, and the
// sequencer states.
// ----------------------------------------------------------------------------
package fla_pkg;

  localparam int DEF_MAX_FREE_BLOCKS = 16;
  localparam int DEF_ADDR_WIDTH      = 16;

  localparam int FIELD_W     = 16;
  localparam int COUNT_W     = 5;
  localparam int ACTION_W    = 2;
  localparam int STATUS_W    = 2;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_ADDR_W-1:0] CFG_FIT_POLICY = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_OS_START   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_OS_SIZE    = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_USER_SIZE  = 2'd3;

  localparam logic               RST_FIT_POLICY = 1'b0;
  localparam logic [FIELD_W-1:0] RST_OS_START   = 16'd0;
  localparam logic [FIELD_W-1:0] RST_OS_SIZE    = 16'd4096;
  localparam logic [FIELD_W-1:0] RST_USER_SIZE  = 16'd61440;
  localparam logic [FIELD_W-1:0] USED_MAX       = 16'hFFFF;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ALLOC   = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_RESTORE = 2'd2
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_NO_FIT = 2'd1,
    STAT_FULL   = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_ALLOC_UPD,
    S_REL_HI,
    S_REL_INS,
    S_SHDN,
    S_SHUP,
    S_RESP
  } state_t;

endpackage

FILE: rtl/fla_ram.sv
// ----------------------------------------------------------------------------
// fla_ram
// Generic simple dual-port RAM: one write port and one read port with a
// registered read.
// ----------------------------------------------------------------------------
module fla_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/free_list_allocator.sv
// ----------------------------------------------------------------------------
// free_list_allocator
// Address-ordered free-region table with first-fit or best-fit allocation,
// coalescing release and restore of the initial pool.
// ----------------------------------------------------------------------------
//  Channel  Direction  Ports                          Contents
//  in       slave      in_tvalid/tready/tdata/tuser   one request item
//  out      master     out_tvalid/tready/tdata        one result item per request
//  cfg      write      cfg_we/cfg_addr/cfg_wdata      policy and pool geometry
//
//  The region table sits in a RAM with one read and one write port, so every
//  pass over the table moves one entry per cycle. An allocate scans the table
//  and, when an exact fit removes an entry, shifts the entries behind it one
//  place toward the front. A release scans to its insert or merge point and
//  may shift entries to open or close a gap; a restore rewrites entry zero.
//  After reset the table entry zero is written in S_INIT before in_tready
//  rises. A stalled result waits in the output register; the next item is
//  accepted meanwhile but its result waits until the register is free.
// ----------------------------------------------------------------------------
module free_list_allocator
  import fla_pkg::*;
#(
  parameter int MAX_FREE_BLOCKS = DEF_MAX_FREE_BLOCKS,
  parameter int ADDR_WIDTH      = DEF_ADDR_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // req_size, block_start
  input  logic [ACTION_W-1:0]    in_tuser,   // action
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // status, granted_start, used_total, free_blocks
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int AW = ADDR_WIDTH;
  localparam int IW = $clog2(MAX_FREE_BLOCKS);
  localparam int CW = $clog2(MAX_FREE_BLOCKS + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_FREE_BLOCKS);

  // Configuration registers.
  logic               fit_policy_r;
  logic [FIELD_W-1:0] os_start_r;
  logic [FIELD_W-1:0] os_size_r;
  logic [FIELD_W-1:0] user_size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_policy_r <= RST_FIT_POLICY;
      os_start_r   <= RST_OS_START;
      os_size_r    <= RST_OS_SIZE;
      user_size_r  <= RST_USER_SIZE;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_FIT_POLICY: fit_policy_r <= cfg_wdata[0];
        CFG_OS_START:   os_start_r   <= cfg_wdata;
        CFG_OS_SIZE:    os_size_r    <= cfg_wdata;
        CFG_USER_SIZE:  user_size_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Sequencer state.
  state_t               state_r, state_nxt;
  logic [CW-1:0]        idx_r, idx_nxt;
  logic                 pend_vld_r, pend_vld_nxt;
  logic [IW-1:0]        pend_idx_r, pend_idx_nxt;
  action_t              act_r, act_nxt;
  logic [AW-1:0]        req_r, req_nxt;
  logic [AW-1:0]        bs_r, bs_nxt;
  logic [AW:0]          e_r, e_nxt;
  logic                 found_r, found_nxt;
  logic [IW-1:0]        pick_idx_r, pick_idx_nxt;
  logic [AW-1:0]        pick_start_r, pick_start_nxt;
  logic [AW-1:0]        pick_size_r, pick_size_nxt;
  logic [AW-1:0]        lo_sum_r, lo_sum_nxt;
  logic [CW-1:0]        ins_idx_r, ins_idx_nxt;
  status_t              status_r, status_nxt;
  logic [FIELD_W-1:0]   grant_r, grant_nxt;
  logic [FIELD_W-1:0]   used_r, used_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic                 resp_r, resp_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  // Region RAM, start in the upper half of each word.
  logic            ram_we;
  logic [IW-1:0]   ram_waddr;
  logic [2*AW-1:0] ram_wdata;
  logic [IW-1:0]   ram_raddr;
  logic [2*AW-1:0] ram_rdata;

  fla_ram #(
    .WIDTH (2 * AW),
    .DEPTH (MAX_FREE_BLOCKS)
  ) u_region_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  logic [AW-1:0]      rd_start;
  logic [AW-1:0]      rd_size;
  logic [AW:0]        rd_end;
  logic               rd_fits;
  logic [FIELD_W-1:0] z16;
  logic [FIELD_W:0]   used_sum;
  logic [FIELD_W-1:0] used_add;
  logic [FIELD_W-1:0] used_sub;
  logic [FIELD_W-1:0] used_upd;
  logic [FIELD_W:0]   pool_start;
  logic               issue_up;
  logic               issue_dn;

  assign rd_start   = ram_rdata[2*AW-1:AW];
  assign rd_size    = ram_rdata[AW-1:0];
  assign rd_end     = {1'b0, rd_start} + {1'b0, rd_size};
  assign rd_fits    = rd_size >= req_r;
  assign z16        = FIELD_W'(req_r);
  assign used_sum   = {1'b0, used_r} + {1'b0, z16};
  assign used_add   = used_sum[FIELD_W] ? USED_MAX : used_sum[FIELD_W-1:0];
  assign used_sub   = (used_r >= z16) ? (used_r - z16) : '0;
  assign used_upd   = (act_r == ACT_ALLOC) ? used_add : used_sub;
  assign pool_start = {1'b0, os_start_r} + {1'b0, os_size_r};
  assign issue_up   = idx_r < count_r;
  assign issue_dn   = idx_r > ins_idx_r;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    pend_vld_nxt   = pend_vld_r;
    pend_idx_nxt   = pend_idx_r;
    act_nxt        = act_r;
    req_nxt        = req_r;
    bs_nxt         = bs_r;
    e_nxt          = e_r;
    found_nxt      = found_r;
    pick_idx_nxt   = pick_idx_r;
    pick_start_nxt = pick_start_r;
    pick_size_nxt  = pick_size_r;
    lo_sum_nxt     = lo_sum_r;
    ins_idx_nxt    = ins_idx_r;
    status_nxt     = status_r;
    grant_nxt      = grant_r;
    used_nxt       = used_r;
    count_nxt      = count_r;
    resp_nxt       = resp_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;
    ram_raddr      = idx_r[IW-1:0];

    case (state_r)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = {AW'(pool_start), AW'(user_size_r)};
        count_nxt = CW'(1);
        used_nxt  = os_size_r;
        state_nxt = resp_r ? S_RESP : S_IDLE;
      end

      S_IDLE: begin
        if (in_tvalid) begin
          act_nxt      = action_t'(in_tuser);
          req_nxt      = AW'(in_tdata[FIELD_W-1:0]);
          bs_nxt       = AW'(in_tdata[2*FIELD_W-1:FIELD_W]);
          e_nxt        = {1'b0, AW'(in_tdata[2*FIELD_W-1:FIELD_W])}
                       + {1'b0, AW'(in_tdata[FIELD_W-1:0])};
          idx_nxt      = '0;
          pend_vld_nxt = 1'b0;
          found_nxt    = 1'b0;
          status_nxt   = STAT_OK;
          grant_nxt    = '0;
          resp_nxt     = 1'b0;
          case (in_tuser)
            ACT_ALLOC, ACT_RELEASE: state_nxt = S_SCAN;
            ACT_RESTORE: begin
              resp_nxt  = 1'b1;
              state_nxt = S_INIT;
            end
            default: state_nxt = S_RESP;
          endcase
        end
      end

      // One entry is read per cycle; its data is judged once the registered read returns it.
      S_SCAN: begin
        pend_vld_nxt = issue_up;
        pend_idx_nxt = idx_r[IW-1:0];
        if (issue_up) begin
          idx_nxt = idx_r + 1'b1;
        end
        if (pend_vld_r && act_r == ACT_ALLOC) begin
          if (rd_fits && (!found_r || rd_size < pick_size_r || !fit_policy_r)) begin
            found_nxt      = 1'b1;
            pick_idx_nxt   = pend_idx_r;
            pick_start_nxt = rd_start;
            pick_size_nxt  = rd_size;
          end
          if (rd_fits && !fit_policy_r) begin
            pend_vld_nxt = 1'b0;
            state_nxt    = S_ALLOC_UPD;
          end
        end else if (pend_vld_r) begin
          if ({1'b0, rd_start} > e_r) begin
            ins_idx_nxt  = CW'(pend_idx_r);
            pend_vld_nxt = 1'b0;
            state_nxt    = S_REL_INS;
          end else if (rd_end == {1'b0, bs_r}) begin
            // Keep the read of the next entry in flight for the upper merge.
            pick_idx_nxt   = pend_idx_r;
            pick_start_nxt = rd_start;
            lo_sum_nxt     = rd_size + req_r;
            state_nxt      = S_REL_HI;
          end else if (e_r == {1'b0, rd_start}) begin
            ram_we       = 1'b1;
            ram_waddr    = pend_idx_r;
            ram_wdata    = {bs_r, AW'(rd_size + req_r)};
            used_nxt     = used_upd;
            pend_vld_nxt = 1'b0;
            state_nxt    = S_RESP;
          end
        end else if (!issue_up) begin
          if (act_r == ACT_ALLOC) begin
            if (found_r) begin
              state_nxt = S_ALLOC_UPD;
            end else begin
              status_nxt = STAT_NO_FIT;
              state_nxt  = S_RESP;
            end
          end else begin
            ins_idx_nxt = count_r;
            state_nxt   = S_REL_INS;
          end
        end
      end

      S_ALLOC_UPD: begin
        grant_nxt = FIELD_W'(pick_start_r);
        if (pick_size_r > req_r) begin
          ram_we    = 1'b1;
          ram_waddr = pick_idx_r;
          ram_wdata = {AW'(pick_start_r + req_r), AW'(pick_size_r - req_r)};
          used_nxt  = used_upd;
          state_nxt = S_RESP;
        end else begin
          idx_nxt      = CW'(pick_idx_r) + 1'b1;
          pend_vld_nxt = 1'b0;
          state_nxt    = S_SHDN;
        end
      end

      S_REL_HI: begin
        ram_we    = 1'b1;
        ram_waddr = pick_idx_r;
        if (pend_vld_r && e_r == {1'b0, rd_start}) begin
          ram_wdata    = {pick_start_r, AW'(lo_sum_r + rd_size)};
          idx_nxt      = CW'(pick_idx_r) + CW'(2);
          pend_vld_nxt = 1'b0;
          state_nxt    = S_SHDN;
        end else begin
          ram_wdata    = {pick_start_r, lo_sum_r};
          used_nxt     = used_upd;
          pend_vld_nxt = 1'b0;
          state_nxt    = S_RESP;
        end
      end

      S_REL_INS: begin
        if (count_r >= MAX_CNT) begin
          status_nxt = STAT_FULL;
          state_nxt  = S_RESP;
        end else begin
          idx_nxt      = count_r;
          pend_vld_nxt = 1'b0;
          state_nxt    = S_SHUP;
        end
      end

      // Close the gap: each entry moves one place toward the front.
      S_SHDN: begin
        if (pend_vld_r) begin
          ram_we    = 1'b1;
          ram_waddr = IW'(pend_idx_r - 1'b1);
          ram_wdata = ram_rdata;
        end
        pend_vld_nxt = issue_up;
        pend_idx_nxt = idx_r[IW-1:0];
        if (issue_up) begin
          idx_nxt = idx_r + 1'b1;
        end
        if (!pend_vld_r && !issue_up) begin
          count_nxt = count_r - 1'b1;
          used_nxt  = used_upd;
          state_nxt = S_RESP;
        end
      end

      // Open a gap at the insert point, moving entries from the back.
      S_SHUP: begin
        ram_raddr = IW'(idx_r - 1'b1);
        if (pend_vld_r) begin
          ram_we    = 1'b1;
          ram_waddr = IW'(pend_idx_r + 1'b1);
          ram_wdata = ram_rdata;
        end
        pend_vld_nxt = issue_dn;
        pend_idx_nxt = IW'(idx_r - 1'b1);
        if (issue_dn) begin
          idx_nxt = idx_r - 1'b1;
        end
        if (!pend_vld_r && !issue_dn) begin
          ram_we    = 1'b1;
          ram_waddr = IW'(ins_idx_r);
          ram_wdata = {bs_r, req_r};
          count_nxt = count_r + 1'b1;
          used_nxt  = used_upd;
          state_nxt = S_SHUP == S_SHUP ? S_RESP : S_RESP;
        end
      end

      S_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {1'b0, COUNT_W'(count_r), used_r, grant_r, status_r};
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      pend_vld_r  <= 1'b0;
      count_r     <= '0;
      used_r      <= '0;
      resp_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_vld_r  <= pend_vld_nxt;
      count_r     <= count_nxt;
      used_r      <= used_nxt;
      resp_r      <= resp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    pend_idx_r   <= pend_idx_nxt;
    act_r        <= act_nxt;
    req_r        <= req_nxt;
    bs_r         <= bs_nxt;
    e_r          <= e_nxt;
    found_r      <= found_nxt;
    pick_idx_r   <= pick_idx_nxt;
    pick_start_r <= pick_start_nxt;
    pick_size_r  <= pick_size_nxt;
    lo_sum_r     <= lo_sum_nxt;
    ins_idx_r    <= ins_idx_nxt;
    status_r     <= status_nxt;
    grant_r      <= grant_nxt;
    out_data_r   <= out_data_nxt;
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MAX_CNT)
    else $error("free region count exceeds the table depth");

  a_shdn_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHDN && pend_vld_r) |-> (pend_idx_r != '0))
    else $error("table compaction would write below entry zero");

  a_full_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_REL_INS && count_r >= MAX_CNT) |=>
      (state_r == S_RESP && $stable(count_r) && $stable(used_r)))
    else $error("release into a full table changed the table");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("a new item was accepted while one is still in work");
`endif

endmodule
